>>> src/gcb_pkg.sv
// ============================================================================
// gcb_pkg
// shared types, codes and helpers of the gray canvas glyph blitter
// ============================================================================
package gcb_pkg;

    // default frame geometry
    localparam int FRAME_WIDTH_DEF  = 256;
    localparam int FRAME_HEIGHT_DEF = 128;

    // longest row segment of one word
    localparam int SEG_MAX = 64;

    // address field of a command, sized for the largest frame (4096 x 4096)
    localparam int ADDR_MAX_W = 24;

    // entries of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        MODE_FILL  = 2'd0,
        MODE_COVER = 2'd1,
        MODE_MONO  = 2'd2,
        MODE_READ  = 2'd3
    } gcb_mode_t;

    typedef enum logic {
        CFG_X_OFFSET = 1'b0,
        CFG_Y_OFFSET = 1'b1
    } gcb_cfg_idx_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_RUN
    } gcb_back_state_t;

    // one classified command, front to back
    typedef struct packed {
        gcb_mode_t               mode;
        logic                    ok;     // read coordinate inside the frame
        logic [ADDR_MAX_W-1:0]   addr;   // read address, or base of the drawn row
        logic signed [16:0]      dx0;    // first drawing column after offset
        logic [6:0]              count;  // saturated pixel count
        logic [7:0]              gray;
        logic [7:0]              alpha;
        logic [63:0]             bits;
    } gcb_cmd_t;

    // bits needed to index n entries, at least one
    function automatic int width_of(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

>>> src/gcb_front.sv
// ============================================================================
// gcb_front
// accepts words, applies the offsets, clips the row and queues commands
// ============================================================================
module gcb_front #(
    parameter int FRAME_WIDTH  = gcb_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = gcb_pkg::FRAME_HEIGHT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [1:0]        s_tuser,
    input  logic [119:0]      s_tdata,
    input  logic              clearing,
    input  logic              q_full,
    output logic              q_push,
    output gcb_pkg::gcb_cmd_t q_cmd
);
    import gcb_pkg::*;

    localparam int ROW_W = width_of(FRAME_HEIGHT);
    localparam int COL_W = width_of(FRAME_WIDTH);

    logic signed [15:0] x_offset_reg, y_offset_reg;
    logic signed [15:0] in_x, in_y;
    logic [6:0]         in_count, cnt_sat;
    gcb_mode_t          mode;
    logic signed [16:0] dy, dx0;
    logic               row_ok, rd_ok, is_read;
    logic [ROW_W-1:0]   row_sel;
    logic [COL_W-1:0]   col_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_offset_reg <= '0;
            y_offset_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_X_OFFSET) x_offset_reg <= cfg_data;
            else                           y_offset_reg <= cfg_data;
        end
    end

    assign in_x     = s_tdata[15:0];
    assign in_y     = s_tdata[31:16];
    assign in_count = s_tdata[38:32];
    assign mode     = gcb_mode_t'(s_tuser);
    assign is_read  = (mode == MODE_READ);

    always_comb begin
        dy      = 17'(in_y) + 17'(y_offset_reg);
        dx0     = 17'(in_x) + 17'(x_offset_reg);
        cnt_sat = (in_count > 7'(SEG_MAX)) ? 7'(SEG_MAX) : in_count;
        row_ok  = (dy >= 0) && (dy < FRAME_HEIGHT);
        rd_ok   = (in_x >= 0) && (in_x < FRAME_WIDTH) && (in_y >= 0) && (in_y < FRAME_HEIGHT);
        row_sel = is_read ? in_y[ROW_W-1:0] : dy[ROW_W-1:0];
        col_sel = is_read ? in_x[COL_W-1:0] : '0;

        q_cmd.mode  = mode;
        q_cmd.ok    = rd_ok;
        q_cmd.addr  = ADDR_MAX_W'(row_sel) * ADDR_MAX_W'(FRAME_WIDTH) + ADDR_MAX_W'(col_sel);
        q_cmd.dx0   = dx0;
        q_cmd.count = cnt_sat;
        q_cmd.gray  = s_tdata[46:39];
        q_cmd.alpha = s_tdata[54:47];
        q_cmd.bits  = s_tdata[118:55];
    end

    assign s_tready = !q_full && !clearing;
    // drawing words off the frame's rows or with a zero count are taken and dropped here
    assign q_push   = s_tvalid && s_tready && (is_read || (row_ok && (cnt_sat != 7'd0)));

endmodule

>>> src/gcb_queue.sv
// ============================================================================
// gcb_queue
// short command queue between front and back
// ============================================================================
module gcb_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  gcb_pkg::gcb_cmd_t din,
    output logic              full,
    input  logic              pop,
    output gcb_pkg::gcb_cmd_t dout,
    output logic              empty
);
    import gcb_pkg::*;

    localparam int PTR_W = width_of(QUEUE_DEPTH);

    gcb_cmd_t           slots [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     fill_reg, fill_next;

    assign full  = (fill_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign dout  = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)      fill_next = fill_reg + 1'b1;
        else if (pop && !push) fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slots[wr_ptr_reg] <= din;
    end

endmodule

>>> src/gcb_back.sv
// ============================================================================
// gcb_back
// frame store, clearing pass, per-pixel read-modify-write and read results
// ============================================================================
module gcb_back #(
    parameter int FRAME_WIDTH  = gcb_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = gcb_pkg::FRAME_HEIGHT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  gcb_pkg::gcb_cmd_t q_head,
    output logic              q_pop,
    output logic              clearing,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic [0:0]        m_tuser
);
    import gcb_pkg::*;

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = width_of(DEPTH);
    localparam int COL_W  = width_of(FRAME_WIDTH);

    // floor((bg*(255-a) + g*a) / 255), exact for sums up to 255*255
    function automatic logic [7:0] blend255(input logic [7:0] bg, input logic [7:0] g,
                                            input logic [7:0] a);
        logic [15:0] s;
        logic [16:0] t;
        s = (16'(bg) * (16'd255 - 16'(a))) + (16'(g) * 16'(a));
        t = 17'(s) + 17'(s >> 8) + 17'd1;
        return t[15:8];
    endfunction

    logic [7:0]         mem [DEPTH];
    logic [7:0]         rdata_reg;

    gcb_back_state_t    state_reg, state_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    gcb_cmd_t           cmd_reg, cmd_next;
    logic [6:0]         idx_reg, idx_next;

    // pixel stage: read issued last cycle, data in rdata_reg now
    logic               p_valid_reg, p_valid_next;
    logic [ADDR_W-1:0]  p_addr_reg, p_addr_next;
    logic [7:0]         p_alpha_reg, p_alpha_next;
    logic [7:0]         p_gray_reg, p_gray_next;
    logic               p_wr_reg, p_wr_next;
    logic               p_read_reg, p_read_next;
    logic               p_ok_reg, p_ok_next;

    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_pixel_reg, m_pixel_next;
    logic               m_range_reg, m_range_next;

    logic               rd_en, wr_en;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;
    logic [7:0]         wr_data;
    logic signed [17:0] dx;

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        q_pop         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = '0;
        p_valid_next  = 1'b0;
        p_addr_next   = '0;
        p_alpha_next  = '0;
        p_gray_next   = cmd_reg.gray;
        p_wr_next     = 1'b0;
        p_read_next   = 1'b0;
        p_ok_next     = 1'b0;
        dx            = 18'(cmd_reg.dx0) + $signed(18'(idx_reg));

        unique case (state_reg)
            BK_CLEAR: begin
                if (clr_addr_reg == ADDR_W'(DEPTH-1)) state_next = BK_IDLE;
                else clr_addr_next = clr_addr_reg + 1'b1;
            end
            BK_IDLE: begin
                // wait for the pixel stage to drain so reads never see a stale byte
                if (!q_empty && !p_valid_reg) begin
                    if (q_head.mode == MODE_READ) begin
                        if (!m_valid_reg) begin
                            q_pop        = 1'b1;
                            rd_en        = q_head.ok;
                            rd_addr      = q_head.addr[ADDR_W-1:0];
                            p_valid_next = 1'b1;
                            p_read_next  = 1'b1;
                            p_ok_next    = q_head.ok;
                        end
                    end else begin
                        q_pop      = 1'b1;
                        cmd_next   = q_head;
                        idx_next   = '0;
                        state_next = BK_RUN;
                    end
                end
            end
            BK_RUN: begin
                if (dx >= FRAME_WIDTH) begin
                    state_next = BK_IDLE;
                end else begin
                    if (dx >= 0) begin
                        rd_en        = 1'b1;
                        rd_addr      = cmd_reg.addr[ADDR_W-1:0] + ADDR_W'(dx[COL_W-1:0]);
                        p_valid_next = 1'b1;
                        p_addr_next  = rd_addr;
                        case (cmd_reg.mode)
                            MODE_FILL: begin
                                p_alpha_next = cmd_reg.alpha;
                                p_wr_next    = 1'b1;
                            end
                            MODE_COVER: begin
                                p_alpha_next = (idx_reg[6:3] == 4'd0) ?
                                    cmd_reg.bits[{idx_reg[2:0], 3'b000} +: 8] : 8'd0;
                                p_wr_next    = 1'b1;
                            end
                            MODE_MONO: begin
                                // full alpha makes the blend return gray exactly
                                p_alpha_next = 8'hFF;
                                p_wr_next    = cmd_reg.bits[~idx_reg[5:0]];
                            end
                            default: begin
                                p_wr_next = 1'b0;
                            end
                        endcase
                    end
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == cmd_reg.count - 7'd1) state_next = BK_IDLE;
                end
            end
            default: state_next = BK_CLEAR;
        endcase
    end

    always_comb begin
        if (state_reg == BK_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = 8'd0;
        end else begin
            wr_en   = p_valid_reg && !p_read_reg && p_wr_reg;
            wr_addr = p_addr_reg;
            wr_data = blend255(rdata_reg, p_gray_reg, p_alpha_reg);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        m_pixel_next = m_pixel_reg;
        m_range_next = m_range_reg;
        if (p_valid_reg && p_read_reg) begin
            m_valid_next = 1'b1;
            m_pixel_next = p_ok_reg ? rdata_reg : 8'd0;
            m_range_next = p_ok_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_CLEAR;
            clr_addr_reg <= '0;
            idx_reg      <= '0;
            p_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            idx_reg      <= idx_next;
            p_valid_reg  <= p_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        p_addr_reg  <= p_addr_next;
        p_alpha_reg <= p_alpha_next;
        p_gray_reg  <= p_gray_next;
        p_wr_reg    <= p_wr_next;
        p_read_reg  <= p_read_next;
        p_ok_reg    <= p_ok_next;
        m_pixel_reg <= m_pixel_next;
        m_range_reg <= m_range_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rdata_reg <= mem[rd_addr];
    end

    assign clearing   = (state_reg == BK_CLEAR);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_pixel_reg;
    assign m_tuser[0] = m_range_reg;

endmodule

>>> src/gray_canvas_glyph_blitter_unit.sv
// ============================================================================
// gray_canvas_glyph_blitter_unit
// 8-bit grayscale frame store drawn one row segment per word
// ============================================================================
// usage:
//   s_ channel: one word draws a row segment of up to 64 pixels (fill, coverage
//   blend, mono set) or reads one pixel; mode rides on s_tuser
//   m_ channel: one word per read, pixel on m_tdata, in-range flag on m_tuser
//   cfg port: x/y drawing offsets, written while the block is idle
// flow:
//   a word that is not dropped sits in the command queue right after its accepting edge
//   a drawing segment holds the pixel engine until its last pixel is issued or it runs
//   past the right edge, then until the pixel stage drains; each pixel is one frame
//   store read followed by a write, and this read-modify-write sets the drawing rate
//   an idle back end passes a read from the queue head through the frame store read
//   register and the result register to m_tdata; it takes the next read only once the
//   pixel stage has drained and the previous result has been taken
// reset:
//   the frame store is cleared by a pass that writes zero to all FRAME_WIDTH * FRAME_HEIGHT
//   bytes (32768 at the default size); s_tready stays low until it ends
// stalls:
//   a held read result stalls the back end once the next read reaches the
//   queue head; the queue keeps taking words until it fills, then s_tready drops
// ============================================================================
module gray_canvas_glyph_blitter_unit #(
    parameter int FRAME_WIDTH  = gcb_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = gcb_pkg::FRAME_HEIGHT_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_wr_en,
    input  logic         cfg_index,     // 0 x_offset, 1 y_offset
    input  logic [15:0]  cfg_data,
    // segment words in
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,       // mode
    input  logic [119:0] s_tdata,       // x, y, count, gray, fill_alpha, src_bits, pad
    // read results out
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,       // pixel
    output logic [0:0]   m_tuser        // in_range
);
    import gcb_pkg::*;

    gcb_cmd_t push_cmd, head_cmd;
    logic     q_push, q_pop, q_full, q_empty, clearing;

    // front: offsets, clipping, classification
    gcb_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .clearing  (clearing),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    // decoupling queue
    gcb_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (push_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (head_cmd),
        .empty   (q_empty)
    );

    // back: frame store and pixel engine
    gcb_back #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (head_cmd),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> dv/blitter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blitter checker
// keeps its own copy of the gray canvas, repaints it from every accepted
// segment word and compares each read result against the predicted pixel
// ----------------------------------------------------------------------------
module blitter_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [1:0]   s_tuser,
    input  logic [119:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [7:0]   m_tdata,
    input  logic [0:0]   m_tuser,
    output int           mismatches,
    output int           outstanding
);
    import gcb_pkg::*;

    localparam int FRAME_W = FRAME_WIDTH_DEF;
    localparam int FRAME_H = FRAME_HEIGHT_DEF;

    typedef struct {
        logic [7:0] pixel;
        logic       in_range;
    } read_result_t;

    logic [7:0]         canvas [FRAME_W*FRAME_H];
    logic signed [15:0] x_shift;
    logic signed [15:0] y_shift;
    read_result_t       pending_reads [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // floor((bg*(255-a) + fg*a) / 255)
    function automatic logic [7:0] blend_gray(input logic [7:0] bg, input logic [7:0] fg,
                                              input logic [7:0] a);
        int unsigned acc;
        acc = bg * (255 - a) + fg * a;
        return 8'(acc / 255);
    endfunction

    // repaint one row segment of the canvas copy
    task automatic paint_segment(input gcb_mode_t mode, input logic signed [15:0] x,
                                 input logic signed [15:0] y, input logic [6:0] count,
                                 input logic [7:0] gray, input logic [7:0] alpha,
                                 input logic [63:0] bits);
        int row;
        int col;
        int n;
        int i;
        int at;
        row = int'(y) + int'(y_shift);
        n   = (count > SEG_MAX) ? SEG_MAX : int'(count);
        if (row < 0 || row >= FRAME_H)
            return;
        for (i = 0; i < n; i++) begin
            col = int'(x) + int'(x_shift) + i;
            if (col < 0)
                continue;
            if (col >= FRAME_W)
                break;
            at = row * FRAME_W + col;
            case (mode)
                MODE_FILL:  canvas[at] = blend_gray(canvas[at], gray, alpha);
                MODE_COVER: canvas[at] = blend_gray(canvas[at], gray,
                                                    (i < 8) ? bits[8*i +: 8] : 8'd0);
                default: begin
                    if (bits[63-i])
                        canvas[at] = gray;
                end
            endcase
        end
    endtask

    always @(posedge aclk) begin : watch
        int                 pix_i;
        read_result_t       want;
        read_result_t       got;
        logic signed [15:0] wx;
        logic signed [15:0] wy;
        if (!aresetn) begin
            for (pix_i = 0; pix_i < FRAME_W*FRAME_H; pix_i++)
                canvas[pix_i] = 8'd0;
            x_shift = '0;
            y_shift = '0;
            pending_reads.delete();
        end else begin
            // results first: a result never belongs to a word taken at the same edge
            if (m_tvalid && m_tready) begin
                if (pending_reads.size() == 0) begin
                    report_mismatch("read result with none pending", m_tdata, -1);
                end else begin
                    want = pending_reads.pop_front();
                    got.pixel    = m_tdata;
                    got.in_range = m_tuser[0];
                    if (got.pixel !== want.pixel)
                        report_mismatch("pixel", got.pixel, want.pixel);
                    if (got.in_range !== want.in_range)
                        report_mismatch("in_range", got.in_range, want.in_range);
                end
            end
            if (cfg_wr_en) begin
                if (gcb_cfg_idx_t'(cfg_index) == CFG_X_OFFSET)
                    x_shift = cfg_data;
                else
                    y_shift = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                wx = s_tdata[15:0];
                wy = s_tdata[31:16];
                if (gcb_mode_t'(s_tuser) == MODE_READ) begin
                    want.in_range = (wx >= 0 && wx < FRAME_W && wy >= 0 && wy < FRAME_H);
                    want.pixel    = want.in_range ? canvas[int'(wy) * FRAME_W + int'(wx)]
                                                  : 8'd0;
                    pending_reads.push_back(want);
                end else begin
                    paint_segment(gcb_mode_t'(s_tuser), wx, wy, s_tdata[38:32],
                                  s_tdata[46:39], s_tdata[54:47], s_tdata[118:55]);
                end
            end
        end
        outstanding <= pending_reads.size();
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives segment words and offset writes into the gray canvas blitter; a
// directed opening covers edges and clipping, then randomized phases under
// several offset settings paint and read back the canvas with random gaps
// and result back-pressure; the checker judges every read word
// ----------------------------------------------------------------------------
module tb;
    import gcb_pkg::*;

    // drawing words left after the last read drain through a 4-deep queue of segments of up to 64 pixels
    localparam int SETTLE_CYCLES = 400;
    // clearing pass plus the slowest run, several times over
    localparam int LIMIT_CYCLES  = 1_000_000;
    // the last random words run with neither side idling
    localparam int CALM_WORDS    = 150;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic         cfg_index = CFG_X_OFFSET;
    logic [15:0]  cfg_data  = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [1:0]   s_tuser   = MODE_FILL;    // mode
    logic [119:0] s_tdata   = '0;           // x, y, count, gray, fill_alpha, src_bits, pad
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [7:0]   m_tdata;                  // pixel
    logic [0:0]   m_tuser;                  // in_range

    int mismatches;
    int outstanding;
    int cycles      = 0;
    int words_left  = 0;
    bit calm        = 1'b0;
    bit gappy       = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    gray_canvas_glyph_blitter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    blitter_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("tb: errors");
            $finish;
        end
    end

    // result side: stalls come in bursts, some stretches stall-free
    initial begin : result_sink
        int stretch;
        bit stally;
        stretch = 0;
        stally  = 1'b0;
        forever begin
            @(posedge aclk);
            if (stretch == 0) begin
                stretch = $urandom_range(50, 200);
                stally  = ($urandom_range(0, 2) != 0);
            end
            stretch--;
            if (!calm && stally && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // clamp a coordinate into the signed 16-bit field
    function automatic logic [15:0] field16(input int v);
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    // any 16-bit signed value
    function automatic int any16();
        logic signed [15:0] r;
        r = 16'($urandom);
        return int'(r);
    endfunction

    // one word on the segment channel, with an optional idle burst ahead of it
    task automatic send_word(input gcb_mode_t mode, input int x, input int y, input int cnt,
                             input int gray, input int alpha, input logic [63:0] bits);
        logic [15:0] xf;
        logic [15:0] yf;
        xf = field16(x);
        yf = field16(y);
        if (!calm && gappy && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, bits, alpha[7:0], gray[7:0], cnt[6:0], yf, xf};
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    // hold off until every read word is back, then let the pixel engine drain
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_offsets(input int xo, input int yo);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_X_OFFSET;
        cfg_data  <= xo[15:0];
        @(posedge aclk);
        cfg_index <= CFG_Y_OFFSET;
        cfg_data  <= yo[15:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly rows 0..15 so reads land on painted pixels
    function automatic int pick_row();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 15);
        else if (r < 88)
            return $urandom_range(0, 129) - 1;
        return any16();
    endfunction

    // random words under one offset setting; drawing targets are frame coordinates,
    // shifted back by the offsets so they land where intended
    task automatic random_phase(input int n, input int xo, input int yo);
        int        k;
        int        tx;
        int        ty;
        int        cnt;
        int        alpha;
        int        sel;
        gcb_mode_t mode;
        for (k = 0; k < n; k++) begin
            if (k % 32 == 0)
                gappy = ($urandom_range(0, 2) != 0);
            words_left--;
            calm = (words_left < CALM_WORDS);
            ty = pick_row();
            if ($urandom_range(0, 99) < 35) begin
                // read word, raw coordinates
                tx = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 259) - 2 : any16();
                send_word(MODE_READ, tx, ty, $urandom_range(0, 127), $urandom_range(0, 255),
                          $urandom_range(0, 255), {$urandom, $urandom});
            end else begin
                mode = gcb_mode_t'($urandom_range(0, 2));
                sel  = $urandom_range(0, 9);
                if (sel == 0)
                    cnt = $urandom_range(0, 127);
                else if (sel == 1)
                    cnt = SEG_MAX;
                else if (sel == 2)
                    cnt = $urandom_range(1, 4);
                else
                    cnt = $urandom_range(1, SEG_MAX);
                sel   = $urandom_range(0, 9);
                alpha = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(0, 255);
                if ($urandom_range(0, 99) < 85) begin
                    tx = $urandom_range(0, 364) - 64 - xo;
                    ty = ty - yo;
                end else begin
                    tx = any16();
                    ty = any16();
                end
                send_word(mode, tx, ty, cnt, $urandom_range(0, 255), alpha,
                          {$urandom, $urandom});
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        // the clearing pass holds s_tready low
        do @(posedge aclk); while (s_tready !== 1'b1);
        set_offsets(0, 0);

        // directed opening, offsets zero
        send_word(MODE_READ, 0, 0, 1, 0, 0, '0);                          // cleared store
        send_word(MODE_FILL, 0, 0, 64, 255, 255, '0);                     // opaque 64-pixel segment
        send_word(MODE_READ, 63, 0, 1, 0, 0, '0);
        send_word(MODE_READ, 64, 0, 1, 0, 0, '0);                         // just past segment
        send_word(MODE_FILL, 0, 0, 8, 0, 128, '0);                        // half blend
        send_word(MODE_READ, 0, 0, 1, 0, 0, '0);
        send_word(MODE_FILL, 0, 0, 10, 0, 0, '0);                         // transparent fill
        send_word(MODE_COVER, 10, 1, 64, 200, 0, 64'h7F80_40C0_01FE_FF00); // bytes 8+ untouched
        send_word(MODE_READ, 11, 1, 1, 0, 0, '0);
        send_word(MODE_READ, 18, 1, 1, 0, 0, '0);
        send_word(MODE_MONO, 250, 2, 64, 99, 0, 64'hA5C3_0000_FFFF_0001);  // right edge clip
        send_word(MODE_READ, 250, 2, 1, 0, 0, '0);
        send_word(MODE_FILL, -10, 3, 20, 77, 255, '0);                    // left edge clip
        send_word(MODE_READ, 9, 3, 1, 0, 0, '0);
        send_word(MODE_FILL, 0, -1, 64, 255, 255, '0);                    // row above frame
        send_word(MODE_FILL, 0, 128, 64, 255, 255, '0);                   // row below frame
        send_word(MODE_FILL, 0, 5, 0, 255, 255, '0);                      // zero count
        send_word(MODE_FILL, 0, 6, 127, 33, 255, '0);                     // saturates to 64
        send_word(MODE_READ, 64, 6, 1, 0, 0, '0);
        send_word(MODE_READ, -1, 0, 1, 0, 0, '0);                         // out of range reads
        send_word(MODE_READ, 256, 0, 1, 0, 0, '0);
        send_word(MODE_READ, 32767, -32768, 1, 0, 0, '0);
        send_word(MODE_READ, 255, 127, 1, 0, 0, '0);                      // far corner
        send_word(MODE_MONO, 32767, 32767, 127, 255, 255, '1);            // field extremes
        send_word(MODE_READ, -32768, 127, 1, 0, 0, '0);

        // random phases, offsets written only once the block is idle
        words_left = 1150;
        drain_and_settle();
        set_offsets(17, -9);
        random_phase(250, 17, -9);
        drain_and_settle();
        set_offsets(32767, 32767);
        random_phase(250, 32767, 32767);
        drain_and_settle();
        set_offsets(-32768, -32768);                                      // no drawing word reaches the frame
        random_phase(150, -32768, -32768);
        drain_and_settle();
        set_offsets(-100, 60);
        random_phase(250, -100, 60);
        drain_and_settle();
        set_offsets(0, 0);
        random_phase(250, 0, 0);
        drain_and_settle();

        if (mismatches == 0 && outstanding == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
